[hdl/usm_pkg.sv]
// ----------------------------------------------------------------------------
// usm_pkg: shared types and constants for the luma unsharp-mask block
// Payload structs, register indexes, opcodes and the Gaussian weight ROM.
// ----------------------------------------------------------------------------
package usm_pkg;

  // default sizing
  localparam int MAX_WIDTH_DEF        = 1024;
  localparam int MAX_HEIGHT_DEF       = 1024;
  localparam int SIGMA_MAX_DEF        = 2;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  // ROM precision (side weights stored at Q0.20)
  localparam int ROM_FRAC = 20;

  // input opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_STRENGTH = 3'd1;
  localparam logic [2:0] REG_SIGMA    = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] y_in;
    logic [7:0] u_in;
    logic [7:0] v_in;
  } usm_in_t;

  typedef struct packed {
    logic [7:0] y_out;
    logic [7:0] u_out;
    logic [7:0] v_out;
    logic       end_of_frame;
    logic       overrun;
  } usm_out_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [10:0] wdata;
  } usm_cfg_t;

  // side weights k = 1..12 per sigma 1..4, Q0.20
  localparam logic [19:0] GAUSS_ROM [4][12] = '{
    '{20'd253793, 20'd56629, 20'd4648, 20'd0, 20'd0, 20'd0,
      20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0},
    '{20'd184773, 20'd126992, 20'd67974, 20'd28336, 20'd9199, 20'd2326,
      20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0},
    '{20'd132099, 20'd111819, 20'd84699, 20'd57410, 20'd34821, 20'd18899,
      20'd9179, 20'd3989, 20'd1551, 20'd0, 20'd0, 20'd0},
    '{20'd101538, 20'd92452, 20'd79078, 20'd63541, 20'd47963, 20'd34011,
      20'd22656, 20'd14178, 20'd8335, 20'd4603, 20'd2388, 20'd1164}
  };

  // Rounded kernel tap |k| for a given sigma; sigma 0 is the identity kernel.
  // The centre tap takes up whatever is left so the taps sum to one.
  function automatic int gauss_weight(int sig, int k, int frac);
    int shift;
    int half;
    int side_sum;
    int res;
    shift    = ROM_FRAC - frac;
    half     = (1 << shift) >> 1;
    side_sum = 0;
    res      = 0;
    if (sig == 0) begin
      res = (k == 0) ? (1 << frac) : 0;
    end else if (k > 3 * sig) begin
      res = 0;
    end else if (k > 0) begin
      res = (int'(GAUSS_ROM[sig-1][k-1]) + half) >> shift;
    end else begin
      for (int j = 1; j <= 12; j++) begin
        if (j <= 3 * sig) begin
          side_sum = side_sum + ((int'(GAUSS_ROM[sig-1][j-1]) + half) >> shift);
        end
      end
      res = (1 << frac) - 2 * side_sum;
    end
    return res;
  endfunction

endpackage

[hdl/usm_chan_if.sv]
// ----------------------------------------------------------------------------
// usm_chan_if: valid/ready channel
// Carries one request per clock at which valid and ready are both high.
// ----------------------------------------------------------------------------
interface usm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/unsharp_mask_luma_sharpen_top.sv]
// ----------------------------------------------------------------------------
// unsharp_mask_luma_sharpen_top: luma sharpening by unsharp masking
// Gaussian blur over a ring of line stores, Y + (Y - blur) * strength.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  : YUV444 pixels in raster order (opcode pixel) or drain ticks.
//   pix_out : sharpened Y, delayed U/V, end_of_frame and sticky overrun.
//   cfg     : register writes (enable, strength, sigma, width, height),
//             always ready; registers are sampled on a frame's first pixel.
// A pixel leaves when pixel p + D arrives, D = min(r,H-1)*W + min(r,W-1),
// r = 3*sigma (0 in bypass). After the last pixel, drain ticks emit the rest;
// a pixel that arrives during the drain is dropped and flags overrun.
// Steps: a pixel without a result is accepted, prepared and written; a dropped
// pixel or idle tick is only accepted. A pixel or drain tick with a result also
// walks the (2r+1)^2 window, where one window tap is read per cycle.
// The result sits in an output register; the next request is accepted while
// it waits. A stalled receiver holds the block only when a new result is due.
// Reset clears counters and loads register defaults; the line store needs no clearing.
// ----------------------------------------------------------------------------
module unsharp_mask_luma_sharpen_top #(
  parameter int MAX_WIDTH        = usm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT       = usm_pkg::MAX_HEIGHT_DEF,
  parameter int SIGMA_MAX        = usm_pkg::SIGMA_MAX_DEF,
  parameter int WEIGHT_FRAC_BITS = usm_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  usm_chan_if.sink   pix_in,
  usm_chan_if.source pix_out,
  usm_chan_if.sink   cfg
);
  import usm_pkg::*;

  localparam int F        = WEIGHT_FRAC_BITS;
  localparam int RAD_MAX  = 3 * SIGMA_MAX;
  localparam int LS_ROWS  = 2 * RAD_MAX + 2;
  localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
  localparam int AW   = $clog2(LS_DEPTH);
  localparam int SW   = $clog2(LS_ROWS);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WDW  = $clog2(MAX_WIDTH + 1);
  localparam int HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int RDW  = $clog2(RAD_MAX + 1);
  localparam int DW   = $clog2(2 * RAD_MAX + 1);
  localparam int SGW  = $clog2(SIGMA_MAX + 1);
  localparam int CVW  = CW + 2;
  localparam int RVW  = RW + 2;
  localparam int WW   = F + 1;
  localparam int HSW  = F + 8;
  localparam int ACW  = 2 * F + 8;
  localparam int DFW  = ACW + 1;
  localparam int SDW  = DFW + 9;
  localparam int NW   = SDW + 1;

  localparam logic signed [NW-1:0] SAT_HI     = NW'(255) << (2 * F);
  localparam logic signed [NW-1:0] ROUND_HALF = NW'(1) << (2 * F - 1);

  // state codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_WRITE = 4'd2;
  localparam logic [3:0] ST_SETUP = 4'd3;
  localparam logic [3:0] ST_RUN   = 4'd4;
  localparam logic [3:0] ST_FLUSH = 4'd5;
  localparam logic [3:0] ST_DIFF  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_SUM   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0] state;

  // configuration registers
  logic        enable;
  logic [7:0]  strength;
  logic [1:0]  sigma;
  logic [10:0] frame_width;
  logic [10:0] frame_height;

  // per-frame settings
  logic [WDW-1:0] f_w;
  logic [HDW-1:0] f_h;
  logic [SGW-1:0] f_sig;
  logic [RDW-1:0] f_rad;
  logic [7:0]     f_str;
  logic [PW-1:0]  f_delay;
  logic [PW-1:0]  f_last;

  // stream position
  logic [PW-1:0] in_count;
  logic [CW-1:0] in_col;
  logic [SW-1:0] in_slot;
  logic [PW-1:0] out_count;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic [SW-1:0] out_slot;
  logic          draining;
  logic          overrun_seen;

  // accepted pixel
  logic [7:0] px_y, px_u, px_v;

  // window walker
  logic                  issue_centre;
  logic [DW-1:0]         dx, dy;
  logic [CW-1:0]         cur_col, col0;
  logic signed [CVW-1:0] vcol, vcol0;
  logic [RW-1:0]         cur_row;
  logic signed [RVW-1:0] vrow;
  logic [SW-1:0]         row_slot;

  // line store
  logic [23:0]   mem [LS_DEPTH];
  logic [23:0]   rd_data;
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;

  // accumulate pipeline
  logic           p1_valid, p1_centre, p1_rowend, p1_last;
  logic [WW-1:0]  p1_wx, p1_wy;
  logic           p2_valid, p2_rowend, p2_last;
  logic [WW-1:0]  p2_wy;
  logic [WW+7:0]  p2_prod;
  logic [HSW-1:0] hsum;
  logic           p3_valid, p3_last;
  logic [WW-1:0]  p3_wy;
  logic [HSW-1:0] p3_row;
  logic           p4_valid, p4_last;
  logic [ACW-1:0] p4_prod;
  logic [ACW-1:0] acc;
  logic           acc_done;
  logic [23:0]    centre;

  // sharpening arithmetic
  logic signed [DFW-1:0] diff;
  logic signed [SDW-1:0] sd;
  logic signed [NW-1:0]  num;

  // output register
  logic     o_valid;
  usm_out_t o_data;

  // kernel taps per sigma
  logic [WW-1:0] wt_tab [SIGMA_MAX+1][RAD_MAX+1];

  for (genvar gs = 0; gs <= SIGMA_MAX; gs++) begin : g_sig
    for (genvar gk = 0; gk <= RAD_MAX; gk++) begin : g_tap
      assign wt_tab[gs][gk] = WW'(gauss_weight(gs, gk, F));
    end
  end

  // handshakes
  logic in_acc;
  logic out_free;
  assign pix_in.ready  = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_acc        = pix_in.valid && pix_in.ready;
  assign out_free      = !o_valid || pix_out.ready;
  assign pix_out.valid = o_valid;
  assign pix_out.data  = o_data;

  // frame settings sampled on the first pixel
  logic           latch_en;
  logic [SGW-1:0] sig_cl;
  logic           active;
  logic [WDW-1:0] w_new;
  logic [HDW-1:0] h_new;

  always_comb begin
    latch_en = in_acc && (pix_in.data.opcode == OP_PIXEL) && !draining &&
               (in_count == '0);
    sig_cl = (32'(sigma) > SIGMA_MAX) ? SGW'(SIGMA_MAX) : SGW'(sigma);
    active = enable && (strength != 8'd0) && (sig_cl != '0);
    if (frame_width == 11'd0) begin
      w_new = WDW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_new = WDW'(MAX_WIDTH);
    end else begin
      w_new = WDW'(frame_width);
    end
    if (frame_height == 11'd0) begin
      h_new = HDW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_new = HDW'(MAX_HEIGHT);
    end else begin
      h_new = HDW'(frame_height);
    end
  end

  // frame delay and last pixel index
  logic [RDW-1:0] rad_h, rad_w;
  always_comb begin
    rad_h = (32'(f_rad) < 32'(f_h) - 1) ? f_rad : RDW'(32'(f_h) - 1);
    rad_w = (32'(f_rad) < 32'(f_w) - 1) ? f_rad : RDW'(32'(f_w) - 1);
  end

  // window taps
  logic [DW-1:0]  two_r;
  logic [RDW-1:0] dist_x, dist_y;
  logic [WW-1:0]  wx, wy;
  logic           row_end, elem_last;
  logic           run_issue;
  logic           in_last, out_last;

  always_comb begin
    two_r     = DW'({f_rad, 1'b0});
    dist_x    = (dx < DW'(f_rad)) ? RDW'(DW'(f_rad) - dx) : RDW'(dx - DW'(f_rad));
    dist_y    = (dy < DW'(f_rad)) ? RDW'(DW'(f_rad) - dy) : RDW'(dy - DW'(f_rad));
    wx        = wt_tab[f_sig][dist_x];
    wy        = wt_tab[f_sig][dist_y];
    row_end   = (dx == two_r);
    elem_last = row_end && (dy == two_r);
    run_issue = (state == ST_RUN);
    in_last   = (in_count == f_last);
    out_last  = (out_count == f_last);
  end

  // window origin
  logic [RDW-1:0]        m_row;
  logic [RW-1:0]         row0;
  logic [SW-1:0]         slot0;
  logic [CW-1:0]         col_start;
  logic signed [CVW-1:0] vcol_start;
  logic signed [RVW-1:0] vrow_start;

  always_comb begin
    m_row      = (RW'(f_rad) > out_row) ? RDW'(out_row) : f_rad;
    row0       = out_row - RW'(m_row);
    slot0      = (out_slot >= SW'(m_row)) ? (out_slot - SW'(m_row)) :
                 SW'({1'b0, out_slot} + (SW+1)'(LS_ROWS) - (SW+1)'(m_row));
    col_start  = (CW'(f_rad) > out_col) ? '0 : (out_col - CW'(f_rad));
    vcol_start = $signed(CVW'(out_col)) - $signed(CVW'(f_rad));
    vrow_start = $signed(RVW'(out_row)) - $signed(RVW'(f_rad));
  end

  // line store ports
  always_comb begin
    mem_we  = (state == ST_WRITE);
    wr_addr = AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col);
    mem_re  = run_issue;
    if (issue_centre) begin
      rd_addr = AW'(out_slot) * AW'(MAX_WIDTH) + AW'(out_col);
    end else begin
      rd_addr = AW'(row_slot) * AW'(MAX_WIDTH) + AW'(cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {px_y, px_u, px_v};
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // final clip and round
  logic signed [NW-1:0] num_rnd;
  logic [7:0]           res;
  always_comb begin
    num_rnd = num + ROUND_HALF;
    if (num <= 0) begin
      res = 8'd0;
    end else if (num >= SAT_HI) begin
      res = 8'd255;
    end else begin
      res = num_rnd[2*F +: 8];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      enable       <= 1'b0;
      strength     <= 8'd0;
      sigma        <= 2'd1;
      frame_width  <= 11'd1024;
      frame_height <= 11'd1024;
      in_count     <= '0;
      in_col       <= '0;
      in_slot      <= '0;
      out_count    <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_slot     <= '0;
      draining     <= 1'b0;
      overrun_seen <= 1'b0;
      o_valid      <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
      p4_valid     <= 1'b0;
      acc_done     <= 1'b0;
    end else begin
      // register writes
      if (cfg.valid) begin
        unique case (cfg.data.addr)
          REG_ENABLE:   enable       <= cfg.data.wdata[0];
          REG_STRENGTH: strength     <= cfg.data.wdata[7:0];
          REG_SIGMA:    sigma        <= cfg.data.wdata[1:0];
          REG_WIDTH:    frame_width  <= cfg.data.wdata;
          REG_HEIGHT:   frame_height <= cfg.data.wdata;
          default: ;
        endcase
      end

      // result taken; a new one loaded in ST_FIN keeps it set
      if (o_valid && pix_out.ready && (state != ST_FIN)) begin
        o_valid <= 1'b0;
      end

      // pipeline valids
      p1_valid <= run_issue;
      p2_valid <= p1_valid && !p1_centre;
      p3_valid <= p2_valid && p2_rowend;
      p4_valid <= p3_valid;
      if (p4_valid && p4_last) begin
        acc_done <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (pix_in.data.opcode == OP_DRAIN) begin
              if (draining) begin
                state <= ST_SETUP;
              end
            end else if (draining) begin
              overrun_seen <= 1'b1;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: state <= ST_WRITE;
        ST_WRITE: begin
          in_count <= in_count + 1'b1;
          if ({1'b0, in_col} + 1'b1 == (CW+1)'(f_w)) begin
            in_col  <= '0;
            in_slot <= (in_slot == SW'(LS_ROWS - 1)) ? '0 : in_slot + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
          if (in_last) begin
            draining <= 1'b1;
          end
          state <= (in_count >= f_delay) ? ST_SETUP : ST_IDLE;
        end
        ST_SETUP: begin
          acc_done <= 1'b0;
          state    <= ST_RUN;
        end
        ST_RUN: begin
          if (!issue_centre && elem_last) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (acc_done) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_MUL;
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            o_valid <= 1'b1;
            state   <= ST_IDLE;
            if (out_last) begin
              // frame done: rewind everything
              in_count     <= '0;
              in_col       <= '0;
              in_slot      <= '0;
              out_count    <= '0;
              out_col      <= '0;
              out_row      <= '0;
              out_slot     <= '0;
              draining     <= 1'b0;
              overrun_seen <= 1'b0;
            end else begin
              out_count <= out_count + 1'b1;
              if ({1'b0, out_col} + 1'b1 == (CW+1)'(f_w)) begin
                out_col  <= '0;
                out_row  <= out_row + 1'b1;
                out_slot <= (out_slot == SW'(LS_ROWS - 1)) ? '0 : out_slot + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // capture request and frame settings
    if (in_acc) begin
      px_y <= pix_in.data.y_in;
      px_u <= pix_in.data.u_in;
      px_v <= pix_in.data.v_in;
    end
    if (latch_en) begin
      f_w   <= w_new;
      f_h   <= h_new;
      f_sig <= active ? sig_cl : '0;
      f_rad <= active ? RDW'(3 * 32'(sig_cl)) : '0;
      f_str <= strength;
    end
    if (state == ST_PREP) begin
      f_delay <= PW'(32'(rad_h) * 32'(f_w) + 32'(rad_w));
      f_last  <= PW'(32'(f_w) * 32'(f_h) - 1);
    end

    // window walk: centre first, then rows top to bottom
    if (state == ST_SETUP) begin
      issue_centre <= 1'b1;
      dx           <= '0;
      dy           <= '0;
      cur_col      <= col_start;
      col0         <= col_start;
      vcol         <= vcol_start;
      vcol0        <= vcol_start;
      cur_row      <= row0;
      vrow         <= vrow_start;
      row_slot     <= slot0;
    end else if (run_issue) begin
      if (issue_centre) begin
        issue_centre <= 1'b0;
      end else if (row_end) begin
        dx      <= '0;
        dy      <= dy + 1'b1;
        cur_col <= col0;
        vcol    <= vcol0;
        vrow    <= vrow + 1'b1;
        if (!vrow[RVW-1] && ({1'b0, cur_row} + 1'b1 < (RW+1)'(f_h))) begin
          cur_row  <= cur_row + 1'b1;
          row_slot <= (row_slot == SW'(LS_ROWS - 1)) ? '0 : row_slot + 1'b1;
        end
      end else begin
        dx   <= dx + 1'b1;
        vcol <= vcol + 1'b1;
        if (!vcol[CVW-1] && ({1'b0, cur_col} + 1'b1 < (CW+1)'(f_w))) begin
          cur_col <= cur_col + 1'b1;
        end
      end
    end

    // stage 1: tags alongside the read
    p1_centre <= issue_centre;
    p1_wx     <= wx;
    p1_wy     <= wy;
    p1_rowend <= row_end;
    p1_last   <= elem_last;

    // stage 2: horizontal tap product
    if (p1_valid && p1_centre) begin
      centre <= rd_data;
    end
    p2_prod   <= p1_wx * rd_data[23:16];
    p2_wy     <= p1_wy;
    p2_rowend <= p1_rowend;
    p2_last   <= p1_last;

    // stage 3: row sum
    if (p2_valid) begin
      if (p2_rowend) begin
        p3_row <= HSW'(hsum + p2_prod);
        hsum   <= '0;
      end else begin
        hsum <= HSW'(hsum + p2_prod);
      end
    end
    p3_wy   <= p2_wy;
    p3_last <= p2_last;

    // stage 4: vertical tap product
    p4_prod <= ACW'(p3_wy * p3_row);
    p4_last <= p3_last;

    // stage 5: blur accumulator
    if (p4_valid) begin
      acc <= acc + p4_prod;
    end
    if (state == ST_SETUP) begin
      hsum <= '0;
      acc  <= '0;
    end

    // sharpen: Y + s * (Y - blur), all in Q.2F
    if (state == ST_DIFF) begin
      diff <= $signed(DFW'({centre[23:16], {(2*F){1'b0}}})) - $signed(DFW'(acc));
    end
    if (state == ST_MUL) begin
      sd <= diff * $signed({1'b0, f_str});
    end
    if (state == ST_SUM) begin
      num <= $signed(NW'({centre[23:16], {(2*F){1'b0}}})) + NW'(sd);
    end

    // output register
    if (state == ST_FIN && out_free) begin
      o_data.y_out        <= res;
      o_data.u_out        <= centre[15:8];
      o_data.v_out        <= centre[7:0];
      o_data.end_of_frame <= out_last;
      o_data.overrun      <= overrun_seen;
    end
  end

endmodule

[verif/usm_checker.sv]
// ----------------------------------------------------------------------------
// usm_checker: scoreboard for the luma unsharp-mask block
// Watches the pixel, result and register channels. It keeps its own copy of
// the line stores and the frame counters, forms each expected sharpened pixel
// when the request that releases it is accepted, and compares the results in
// order.
// ----------------------------------------------------------------------------
module usm_checker
  import usm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  usm_chan_if  pin,
  usm_chan_if  pout,
  usm_chan_if  cfg,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIG_MAX  = SIGMA_MAX_DEF;
  localparam int RAD_MAX  = 3 * SIG_MAX;
  localparam int LINES    = 2 * RAD_MAX + 2;
  localparam int W_MAX    = MAX_WIDTH_DEF;
  localparam int H_MAX    = MAX_HEIGHT_DEF;
  localparam int FRAC     = WEIGHT_FRAC_BITS_DEF;
  localparam int SHIFT    = ROM_FRAC - FRAC;

  // pixel ring, Y:U:V
  logic [23:0] ring [LINES * W_MAX];

  int unsigned in_col, in_row, out_col, out_row;
  bit          draining, dropped_seen;

  // programmed registers
  logic        reg_en;
  logic [7:0]  reg_str;
  logic [1:0]  reg_sig;
  logic [10:0] reg_w, reg_h;

  // settings captured on the first pixel of a frame
  int unsigned       fr_w, fr_h, fr_rad, fr_str, fr_delay;
  longint unsigned   taps [RAD_MAX + 1];

  usm_out_t sharpened_q [$];

  assign pending = sharpened_q.size();

  function automatic int unsigned ring_loc(int unsigned row, int unsigned col);
    return (row % LINES) * W_MAX + (col % W_MAX);
  endfunction

  function automatic int unsigned clip_idx(int v, int unsigned hi);
    if (v < 0) return 0;
    if (v > int'(hi)) return hi;
    return v;
  endfunction

  task automatic capture_frame();
    int unsigned     sg;
    longint unsigned side;
    side   = 0;
    fr_w   = (reg_w == 0) ? 1 : ((reg_w > W_MAX) ? W_MAX : reg_w);
    fr_h   = (reg_h == 0) ? 1 : ((reg_h > H_MAX) ? H_MAX : reg_h);
    sg     = (reg_sig > SIG_MAX) ? SIG_MAX : reg_sig;
    fr_rad = (reg_en && reg_str != 0 && sg != 0) ? 3 * sg : 0;
    fr_str = reg_str;
    for (int k = 0; k <= RAD_MAX; k++) taps[k] = 0;
    for (int k = 1; k <= int'(fr_rad); k++) begin
      taps[k] = (longint'(GAUSS_ROM[sg-1][k-1]) + ((1 << SHIFT) >> 1)) >> SHIFT;
      side += taps[k];
    end
    taps[0]  = (64'd1 << FRAC) - 2 * side;
    fr_delay = ((fr_rad < fr_h - 1) ? fr_rad : fr_h - 1) * fr_w +
               ((fr_rad < fr_w - 1) ? fr_rad : fr_w - 1);
  endtask

  // Sharpen the pixel at the output pointer and queue it.
  task automatic release_pixel(output bit last);
    longint unsigned acc, hsum;
    longint          num;
    logic [23:0]     mid;
    int unsigned     row, col, lum;
    usm_out_t        o;
    acc = 0;
    mid = ring[ring_loc(out_row, out_col)];
    for (int dy = -int'(fr_rad); dy <= int'(fr_rad); dy++) begin
      row  = clip_idx(int'(out_row) + dy, fr_h - 1);
      hsum = 0;
      for (int dx = -int'(fr_rad); dx <= int'(fr_rad); dx++) begin
        col  = clip_idx(int'(out_col) + dx, fr_w - 1);
        hsum += taps[dx < 0 ? -dx : dx] * ring[ring_loc(row, col)][23:16];
      end
      acc += taps[dy < 0 ? -dy : dy] * hsum;
    end
    num = (longint'(mid[23:16]) << (2 * FRAC)) * (1 + fr_str) - longint'(acc * fr_str);
    if (num <= 0) lum = 0;
    else if (num >= (longint'(255) << (2 * FRAC))) lum = 255;
    else lum = (num + (longint'(1) << (2 * FRAC - 1))) >> (2 * FRAC);
    last           = (out_row * fr_w + out_col) == fr_w * fr_h - 1;
    o.y_out        = lum[7:0];
    o.u_out        = mid[15:8];
    o.v_out        = mid[7:0];
    o.end_of_frame = last;
    o.overrun      = dropped_seen;
    sharpened_q.push_back(o);
    out_col++;
    if (out_col >= fr_w) begin
      out_col = 0;
      out_row++;
    end
    if (last) begin
      in_col       = 0;
      in_row       = 0;
      out_col      = 0;
      out_row      = 0;
      draining     = 0;
      dropped_seen = 0;
    end
  endtask

  task automatic take_request(usm_in_t it);
    int unsigned pos;
    bit          ended, last_in;
    ended = 0;
    if (it.opcode == OP_DRAIN) begin
      if (draining) release_pixel(ended);
    end else if (draining) begin
      dropped_seen = 1;
    end else begin
      if (in_row == 0 && in_col == 0) capture_frame();
      pos = in_row * fr_w + in_col;
      ring[ring_loc(in_row, in_col)] = {it.y_in, it.u_in, it.v_in};
      in_col++;
      if (in_col >= fr_w) begin
        in_col = 0;
        in_row++;
      end
      last_in = pos == fr_w * fr_h - 1;
      if (pos >= fr_delay) release_pixel(ended);
      if (last_in && !ended) draining = 1;
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    usm_out_t e, a;
    if (rst) begin
      in_col       = 0;
      in_row       = 0;
      out_col      = 0;
      out_row      = 0;
      draining     = 0;
      dropped_seen = 0;
      reg_en       = 0;
      reg_str      = 0;
      reg_sig      = 1;
      reg_w        = 11'd1024;
      reg_h        = 11'd1024;
      fail_count   = 0;
      sharpened_q.delete();
      capture_frame();
    end else begin
      // compare results
      if (pout.valid && pout.ready) begin
        a = pout.data;
        if (sharpened_q.size() == 0) begin
          $error("unexpected result: y_out %0d u_out %0d v_out %0d", a.y_out, a.u_out,
                 a.v_out);
          fail_count++;
        end else begin
          e = sharpened_q.pop_front();
          check_field("y_out", e.y_out, a.y_out);
          check_field("u_out", e.u_out, a.u_out);
          check_field("v_out", e.v_out, a.v_out);
          check_field("end_of_frame", e.end_of_frame, a.end_of_frame);
          check_field("overrun", e.overrun, a.overrun);
        end
      end
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.addr)
          REG_ENABLE:   reg_en  = cfg.data.wdata[0];
          REG_STRENGTH: reg_str = cfg.data.wdata[7:0];
          REG_SIGMA:    reg_sig = cfg.data.wdata[1:0];
          REG_WIDTH:    reg_w   = cfg.data.wdata;
          REG_HEIGHT:   reg_h   = cfg.data.wdata;
          default: ;
        endcase
      end
      // pixel and drain requests
      if (pin.valid && pin.ready) take_request(pin.data);
    end
  end

  // leftovers at the end are counted by the top through pending
endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: top level for the luma unsharp-mask block
// Sends whole frames of YUV444 pixels with their drain ticks under several
// register settings and idle patterns; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import usm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT  = 5_000_000;
  localparam int SETTLE = 250;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  int   cycles = 0;
  int   src_idle = 0, snk_idle = 0;
  int   hold_req = 0;
  int   items = 0;

  usm_chan_if #(.payload_t(usm_in_t))  pin_if ();
  usm_chan_if #(.payload_t(usm_out_t)) pout_if ();
  usm_chan_if #(.payload_t(usm_cfg_t)) cfg_if ();

  unsharp_mask_luma_sharpen_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pin_if),
    .pix_out (pout_if),
    .cfg     (cfg_if)
  );

  usm_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .pin        (pin_if),
    .pout       (pout_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  initial begin
    pin_if.valid  = 0;
    pin_if.data   = '0;
    cfg_if.valid  = 0;
    cfg_if.data   = '0;
    pout_if.ready = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    int hold_left, hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      pout_if.ready <= 0;
    end else begin
      pout_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_request(logic op, logic [7:0] y, u, v);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      pin_if.valid <= 0;
      @(negedge clk);
    end
    pin_if.valid <= 1;
    pin_if.data  <= '{opcode: op, y_in: y, u_in: u, v_in: v};
    do @(posedge clk); while (!pin_if.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [10:0] val);
    cfg_if.valid <= 1;
    cfg_if.data  <= '{addr: addr, wdata: val};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // wait until every result is out and the block has settled
  task automatic drain_out();
    pin_if.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_luma(logic [7:0] prev);
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 8'd255 : 8'd0;
      1: return prev + 8'($urandom_range(8)) - 8'd4;
      default: return 8'($urandom);
    endcase
  endfunction

  // One frame: program, send the pixels, then the drain ticks.
  task automatic run_frame(logic en, logic [7:0] str, logic [1:0] sig,
                           logic [10:0] w, logic [10:0] h, bit drop, bit noise);
    int unsigned ew, eh, rad, dly, n, ticks;
    logic [7:0]  y;
    drain_out();
    write_reg(REG_ENABLE, 11'(en));
    write_reg(REG_STRENGTH, 11'(str));
    write_reg(REG_SIGMA, 11'(sig));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_if.valid <= 0;
    ew    = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    eh    = (h == 0) ? 1 : ((h > 1024) ? 1024 : h);
    rad   = (en && str != 0 && sig != 0) ? 3 * ((sig > 2) ? 2 : sig) : 0;
    dly   = ((rad < eh - 1) ? rad : eh - 1) * ew + ((rad < ew - 1) ? rad : ew - 1);
    n     = ew * eh;
    ticks = (dly < n) ? dly : n;
    y     = 8'($urandom);
    // an ignored tick before the frame starts
    if (noise) send_request(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < int'(n); i++) begin
      y = pick_luma(y);
      send_request(OP_PIXEL, y, 8'($urandom), 8'($urandom));
    end
    // a pixel during the drain is dropped and raises overrun
    if (drop && ticks > 0)
      send_request(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < int'(ticks); i++)
      send_request(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    if (noise) send_request(OP_DRAIN, 8'hff, 8'hff, 8'hff);
    items += n + ticks;
  endtask

  initial begin
    int phase;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: bypass, extremes, sigma saturation, tiny frames, overrun
    run_frame(0, 8'd255, 2'd1, 11'd2, 11'd2, 0, 1);
    run_frame(1, 8'd0, 2'd2, 11'd2, 11'd1, 0, 0);
    run_frame(1, 8'd7, 2'd0, 11'd1, 11'd2, 0, 0);
    run_frame(1, 8'd255, 2'd1, 11'd3, 11'd2, 1, 1);
    run_frame(1, 8'd1, 2'd3, 11'd2, 11'd3, 0, 0);
    run_frame(1, 8'd128, 2'd2, 11'd1, 11'd1, 1, 0);

    // random frames over the idle phases
    phase = 0;
    while (items < 900) begin
      case (phase % 4)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 83; snk_idle = 0;  end
        2: begin src_idle = 0;  snk_idle = 83; end
        default: begin src_idle = 23; snk_idle = 23; end
      endcase
      if (phase == 4) begin
        // receiver holds off while pixels keep coming
        drain_out();
        hold_req++;
        run_frame(1, 8'd200, 2'd1, 11'd8, 11'd8, 0, 0);
      end
      repeat (4)
        run_frame($urandom_range(9) != 0,
                  $urandom_range(4) == 0 ? 8'(255 * $urandom_range(1)) : 8'($urandom),
                  2'($urandom_range(3)), 11'($urandom_range(1, 9)),
                  11'($urandom_range(1, 9)), $urandom_range(5) == 0,
                  $urandom_range(3) == 0);
      phase++;
    end

    // zero register values for the frame size
    src_idle = 0;
    snk_idle = 0;
    run_frame(1, 8'd40, 2'd2, 11'd0, 11'd0, 1, 0);
    run_frame(0, 8'd90, 2'd2, 11'd0, 11'd3, 0, 0);

    drain_out();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
